@@ hdl/adc_sample_text_framer_assert.svh @@
// assertion helpers for the framer modules, included by asf_back
`ifndef ADC_SAMPLE_TEXT_FRAMER_ASSERT_SVH
`define ADC_SAMPLE_TEXT_FRAMER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ASF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ASF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/asf_pkg.sv @@
`default_nettype none

package asf_pkg;

  localparam int SAMPLE_W = 12;
  localparam int LIMIT_W  = 12;
  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 6;

  localparam logic [LIMIT_W-1:0] UPPER_RESET = 12'd4000;
  localparam logic [LIMIT_W-1:0] LOWER_RESET = 12'd100;

  // register indexes on the config port
  localparam logic REG_UPPER = 1'b0;
  localparam logic REG_LOWER = 1'b1;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  // one classified sample waiting for the back end
  typedef struct packed {
    logic [CODE_W-1:0] lo;
    logic [CODE_W-1:0] hi;
    logic              nl;
    logic              flag;
  } entry_t;

  // base64 alphabet digit for a six-bit code
  function automatic logic [BYTE_W-1:0] b64_char(input logic [CODE_W-1:0] code);
    logic [BYTE_W-1:0] c;
    c = {2'b00, code};
    if (code < 6'd26) begin
      b64_char = 8'd65 + c;
    end else if (code < 6'd52) begin
      b64_char = 8'd71 + c;
    end else if (code < 6'd62) begin
      b64_char = c - 8'd4;
    end else if (code == 6'd62) begin
      b64_char = 8'd43;
    end else begin
      b64_char = 8'd47;
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/asf_front.sv @@
`default_nettype none

module asf_front #(
  parameter int CHARS_PER_LINE = 62
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sample_valid,
  input  wire logic [asf_pkg::SAMPLE_W-1:0]   sample,
  input  wire logic                           full,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_index,
  input  wire logic [asf_pkg::LIMIT_W-1:0]    cfg_data,
  output logic                                push,
  output asf_pkg::entry_t                     entry
);
  import asf_pkg::*;

  localparam int PAIRS = (CHARS_PER_LINE + 1) / 2;
  localparam int CW    = $clog2(PAIRS + 1);

  logic [LIMIT_W-1:0] upper_limit;
  logic [LIMIT_W-1:0] lower_limit;
  logic [CW-1:0]      pair_count;
  logic [CW-1:0]      pair_count_next;
  logic               line_done;

  assign push      = sample_valid && !full;
  assign line_done = (pair_count == CW'(PAIRS - 1));

  always_comb begin
    entry.lo   = sample[CODE_W-1:0];
    entry.hi   = sample[2*CODE_W-1:CODE_W];
    entry.nl   = line_done;
    entry.flag = (sample > upper_limit) || (sample < lower_limit);
    pair_count_next = line_done ? '0 : pair_count + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= UPPER_RESET;
      lower_limit <= LOWER_RESET;
      pair_count  <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_UPPER: upper_limit <= cfg_data;
          REG_LOWER: lower_limit <= cfg_data;
          default:   upper_limit <= upper_limit;
        endcase
      end
      if (push) begin
        pair_count <= pair_count_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/asf_queue.sv @@
`default_nettype none

module asf_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire asf_pkg::entry_t   push_entry,
  input  wire logic              pop,
  output logic                   full,
  output logic                   head_valid,
  output asf_pkg::entry_t        head
);
  import asf_pkg::*;

  entry_t       slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/asf_back.sv @@
`default_nettype none

module asf_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         head_valid,
  input  wire asf_pkg::entry_t              head,
  output logic                              pop,
  output logic                              text_valid,
  input  wire logic                         text_stall,
  output logic [asf_pkg::BYTE_W-1:0]        text_byte,
  output logic                              line_end,
  output logic                              out_of_range
);
  import asf_pkg::*;

  localparam logic [1:0] PH_LO = 2'd0;
  localparam logic [1:0] PH_HI = 2'd1;
  localparam logic [1:0] PH_NL = 2'd2;

  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic              load;
  logic              last;
  logic [BYTE_W-1:0] byte_next;

  assign load = head_valid && (!text_valid || !text_stall);

  always_comb begin
    last       = 1'b0;
    byte_next  = NEWLINE;
    phase_next = phase;
    unique case (phase)
      PH_LO: begin
        byte_next  = b64_char(head.lo);
        phase_next = PH_HI;
      end
      PH_HI: begin
        byte_next  = b64_char(head.hi);
        last       = !head.nl;
        phase_next = head.nl ? PH_NL : PH_LO;
      end
      PH_NL: begin
        byte_next  = NEWLINE;
        last       = 1'b1;
        phase_next = PH_LO;
      end
      default: begin
        byte_next  = NEWLINE;
        last       = 1'b1;
        phase_next = PH_LO;
      end
    endcase
  end

  assign pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LO;
      text_valid <= 1'b0;
    end else begin
      if (load) begin
        phase      <= phase_next;
        text_valid <= 1'b1;
      end else if (!text_stall) begin
        text_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      text_byte    <= byte_next;
      line_end     <= (phase == PH_NL);
      out_of_range <= head.flag;
    end
  end

`include "adc_sample_text_framer_assert.svh"

  `ASF_ASSERT_NOW(a_mid_item_has_head, phase != PH_LO, head_valid, "item in progress lost its entry")
  `ASF_ASSERT_NOW(a_nl_phase_needs_nl, phase == PH_NL, head.nl, "newline phase on an entry without newline")
  `ASF_ASSERT_NOW(a_line_end_is_newline, text_valid && line_end, text_byte == NEWLINE, "line end on a non-newline beat")
  `ASF_ASSERT_NEXT(a_pop_resets_phase, pop, phase == PH_LO, "phase not back to start after pop")

endmodule

`default_nettype wire

@@ hdl/adc_sample_text_framer.sv @@
// an accepted sample is written into a queue slot, and its beats are registered at the output
// one text beat per cycle unless text_stall holds it: two per sample, three when it closes a line
// the rate is set by the single output register; a 2-entry queue lets input and output stall apart
// reset (synchronous, active high) empties the queue, restarts the line count and
// sets upper_limit to 4000 and lower_limit to 100
`default_nettype none

module adc_sample_text_framer #(
  parameter int CHARS_PER_LINE = 62
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // sample channel
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire logic [asf_pkg::SAMPLE_W-1:0]  sample,
  // config write port: index 0 upper_limit, index 1 lower_limit
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_index,
  input  wire logic [asf_pkg::LIMIT_W-1:0]   cfg_data,
  // text channel
  output logic                               text_valid,
  input  wire logic                          text_stall,
  output logic [asf_pkg::BYTE_W-1:0]         text_byte,
  output logic                               line_end,
  output logic                               out_of_range
);
  import asf_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  logic   head_valid;
  entry_t head;

  // input side stalls only when the queue has no free slot
  assign sample_stall = full;

  // front: range check, digit split and line counting at accept time
  asf_front #(
    .CHARS_PER_LINE (CHARS_PER_LINE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample       (sample),
    .full         (full),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .entry        (push_entry)
  );

  // short queue between the two halves
  asf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: two digits then an optional newline, one beat per cycle unless text_stall holds it
  asf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .line_end     (line_end),
    .out_of_range (out_of_range)
  );

endmodule

`default_nettype wire
